// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the odometry balancer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define DDOB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define DDOB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/ddob_pkg.sv -----
// Types, constants and the arctangent table of the odometry balancer.
package ddob_pkg;

  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,
    OP_RIGHT = 2'd1,
    OP_TIME  = 2'd2,
    OP_START = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_SAMPLE_TICKS     = 2'd0,
    REG_RIGHT_DUTY_START = 2'd1,
    REG_TICK_ANGLE       = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HMUL,
    ST_HEAD,
    ST_CSTART,
    ST_CWAIT,
    ST_XMUL,
    ST_YMUL,
    ST_XADD,
    ST_YADD,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    CRD_IDLE,
    CRD_ROT,
    CRD_QUANT
  } crd_state_t;

  localparam int CRD_W = 34;
  localparam int MAX_CORDIC_STEPS = 24;
  localparam logic signed [CRD_W-1:0] CRD_X0 = 34'sd652032874;

  localparam logic [7:0]  SAMPLE_TICKS_RST = 8'd30;
  localparam logic [7:0]  DUTY_START_RST   = 8'd80;
  localparam logic [11:0] TICK_ANGLE_RST   = 12'd951;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } crd_ctl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [15:0] cos_q15;
    logic signed [15:0] sin_q15;
  } crd_sts_t;

  function automatic logic signed [CRD_W-1:0] crd_atan(input logic [4:0] idx);
    logic signed [CRD_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sh020000000;
      5'd1:    v = 34'sh012E4051E;
      5'd2:    v = 34'sh009FB385B;
      5'd3:    v = 34'sh0051111D4;
      5'd4:    v = 34'sh0028B0D43;
      5'd5:    v = 34'sh00145D7E1;
      5'd6:    v = 34'sh000A2F61E;
      5'd7:    v = 34'sh000517C55;
      5'd8:    v = 34'sh00028BE53;
      5'd9:    v = 34'sh000145F2F;
      5'd10:   v = 34'sh0000A2F98;
      5'd11:   v = 34'sh0000517CC;
      5'd12:   v = 34'sh000028BE6;
      5'd13:   v = 34'sh0000145F3;
      5'd14:   v = 34'sh00000A2FA;
      5'd15:   v = 34'sh00000517D;
      5'd16:   v = 34'sh0000028BE;
      5'd17:   v = 34'sh00000145F;
      5'd18:   v = 34'sh000000A30;
      5'd19:   v = 34'sh000000518;
      5'd20:   v = 34'sh00000028C;
      5'd21:   v = 34'sh000000146;
      5'd22:   v = 34'sh0000000A3;
      5'd23:   v = 34'sh000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ddob_mul.sv -----
// Shared signed multiplier with a registered product.
module ddob_mul #(
  parameter int A_W = 21
) (
  input  logic                      clk,
  input  logic signed [A_W-1:0]     a,
  input  logic signed [15:0]        b,
  output logic signed [A_W+15:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// ----- hdl/ddob_cordic.sv -----
// Iterative CORDIC rotation giving cos and sin of a binary angle in Q1.15.
module ddob_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ddob_pkg::crd_ctl_t ctl,
  output ddob_pkg::crd_sts_t sts
);

  localparam int N    = (STEPS > ddob_pkg::MAX_CORDIC_STEPS) ?
                        ddob_pkg::MAX_CORDIC_STEPS : STEPS;
  localparam int IT_W = (N > 1) ? $clog2(N) : 1;
  localparam int W    = ddob_pkg::CRD_W;

  ddob_pkg::crd_state_t state_r, state_nxt;

  logic signed [W-1:0] x_r, y_r, z_r;
  logic signed [W-1:0] dx, dy, atan_v, xq, yq;
  logic [IT_W-1:0]     iter_r;
  logic                flip_r;
  logic                done_r;
  logic signed [15:0]  cos_r, sin_r;
  logic                flip_in;
  logic [15:0]         ang_in;

  function automatic logic signed [15:0] sat_q15(input logic signed [W-1:0] v);
    logic signed [W:0]    s;
    logic signed [W-15:0] r;
    logic signed [15:0]   q;
    s = (W+1)'(v) + (W+1)'(16384);
    r = (W-14)'(s >>> 15);
    if (r > (W-14)'(32767)) begin
      q = 16'sh7FFF;
    end else if (r < -(W-14)'(32768)) begin
      q = 16'sh8000;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  always_comb begin
    flip_in = (ctl.angle > 16'h4000) && (ctl.angle < 16'hC000);
    ang_in  = flip_in ? (ctl.angle + 16'h8000) : ctl.angle;
    dx      = y_r >>> iter_r;
    dy      = x_r >>> iter_r;
    atan_v  = ddob_pkg::crd_atan(5'(iter_r));
    xq      = flip_r ? -x_r : x_r;
    yq      = flip_r ? -y_r : y_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddob_pkg::CRD_IDLE: begin
        if (ctl.start) begin
          state_nxt = ddob_pkg::CRD_ROT;
        end
      end
      ddob_pkg::CRD_ROT: begin
        if (iter_r == IT_W'(N-1)) begin
          state_nxt = ddob_pkg::CRD_QUANT;
        end
      end
      ddob_pkg::CRD_QUANT: state_nxt = ddob_pkg::CRD_IDLE;
      default:             state_nxt = ddob_pkg::CRD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddob_pkg::CRD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == ddob_pkg::CRD_QUANT);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ddob_pkg::CRD_IDLE: begin
        if (ctl.start) begin
          x_r    <= ddob_pkg::CRD_X0;
          y_r    <= '0;
          z_r    <= {{2{ang_in[15]}}, ang_in, 16'h0000};
          flip_r <= flip_in;
          iter_r <= '0;
        end
      end
      ddob_pkg::CRD_ROT: begin
        if (!z_r[W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_v;
        end
        iter_r <= iter_r + 1'b1;
      end
      ddob_pkg::CRD_QUANT: begin
        cos_r <= sat_q15(xq);
        sin_r <= sat_q15(yq);
      end
      default: begin
      end
    endcase
  end

  assign sts.busy    = (state_r != ddob_pkg::CRD_IDLE);
  assign sts.done    = done_r;
  assign sts.cos_q15 = cos_r;
  assign sts.sin_q15 = sin_r;

endmodule

// ----- hdl/differential_drive_odometry_balancer.sv -----
// Differential-drive odometry and right-wheel duty balancer, top level.
// Left, right and time ticks, starts, and time ticks that do not close a window are each taken
// with in_ready held high and the block left idle. A time tick that closes a window occupies the
// block while it runs the bearing step through the one shared multiplier, the CORDIC iterations
// of the rotation unit, and the x and y products through the same multiplier, followed by rounding
// and position accumulation. A finished result waits in the output register; a further window
// end cannot complete until that result is taken.
`include "assert_macros.svh"

module differential_drive_odometry_balancer #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_target_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_window_left,
  output logic [11:0]        out_window_right,
  output logic [7:0]         out_right_duty,
  output logic signed [16:0] out_tick_difference,
  output logic [15:0]        out_bearing,
  output logic signed [31:0] out_x_pos,
  output logic signed [31:0] out_y_pos,
  output logic               out_finished
);

  localparam int HALF_W = 13 + FRAC_BITS - 1;
  localparam int A_W    = HALF_W + 1;
  localparam int PW     = A_W + 16;
  localparam int SC_W   = PW - 15;

  ddob_pkg::seq_state_t state_r, state_nxt;

  logic [7:0]  sample_ticks_r, duty_start_r;
  logic [11:0] tick_angle_r;

  logic        running_r;
  logic [7:0]  time_count_r;
  logic [15:0] total_left_r, total_right_r, goal_r, heading_r;
  logic [11:0] win_left_r, win_right_r;
  logic [7:0]  duty_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [HALF_W-1:0]  half_r;
  logic signed [SC_W-1:0] sc_r;

  logic        out_valid_r, out_fin_r;
  logic [11:0] out_wl_r, out_wr_r;
  logic [7:0]  out_duty_r;
  logic signed [16:0] out_tdiff_r;
  logic [15:0] out_bearing_r;
  logic signed [31:0] out_x_r, out_y_r;

  logic                   accept;
  ddob_pkg::opcode_t      op;
  logic [7:0]             tc_inc, limit;
  logic                   win_end;
  logic signed [A_W-1:0]  mul_a;
  logic signed [15:0]     mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [PW:0]     rnd;
  logic signed [SC_W-1:0] sc_nxt;
  logic signed [33:0]     pos_sum;
  logic signed [31:0]     pos_sat;
  logic signed [31:0]     pos_cur;
  logic signed [12:0]     wdiff;
  logic                   fin;
  logic                   load_out;
  ddob_pkg::crd_ctl_t     crd_ctl;
  ddob_pkg::crd_sts_t     crd_sts;

  ddob_mul #(.A_W(A_W)) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  ddob_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crd_ctl),
    .sts   (crd_sts)
  );

  assign in_ready      = (state_r == ddob_pkg::ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign op            = ddob_pkg::opcode_t'(in_opcode);
  assign tc_inc        = (time_count_r == 8'hFF) ? time_count_r : time_count_r + 8'd1;
  assign limit         = (sample_ticks_r == 8'd0) ? 8'd1 : sample_ticks_r;
  assign win_end       = running_r && (op == ddob_pkg::OP_TIME) && (tc_inc >= limit);
  assign wdiff         = $signed({1'b0, win_right_r}) - $signed({1'b0, win_left_r});
  assign crd_ctl.start = (state_r == ddob_pkg::ST_CSTART);
  assign crd_ctl.angle = heading_r;
  assign fin           = ({1'b0, total_left_r} + {1'b0, total_right_r}) > {goal_r, 1'b0};
  assign load_out      = (state_r == ddob_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    case (state_r)
      ddob_pkg::ST_HMUL: begin
        mul_a = A_W'(wdiff);
        mul_b = $signed({4'b0000, tick_angle_r});
      end
      ddob_pkg::ST_XMUL: begin
        mul_a = $signed({1'b0, half_r});
        mul_b = crd_sts.cos_q15;
      end
      default: begin
        mul_a = $signed({1'b0, half_r});
        mul_b = crd_sts.sin_q15;
      end
    endcase
  end

  always_comb begin
    rnd     = (PW+1)'(prod) + (prod[PW-1] ? (PW+1)'(16383) : (PW+1)'(16384));
    sc_nxt  = SC_W'(rnd >>> 15);
    pos_cur = (state_r == ddob_pkg::ST_XADD) ? pos_x_r : pos_y_r;
    pos_sum = 34'(pos_cur) + 34'(sc_r);
    if (pos_sum > 34'sh07FFFFFFF) begin
      pos_sat = 32'sh7FFFFFFF;
    end else if (pos_sum < -34'sh080000000) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddob_pkg::ST_IDLE: begin
        if (accept && win_end) begin
          state_nxt = ddob_pkg::ST_HMUL;
        end
      end
      ddob_pkg::ST_HMUL:   state_nxt = ddob_pkg::ST_HEAD;
      ddob_pkg::ST_HEAD:   state_nxt = ddob_pkg::ST_CSTART;
      ddob_pkg::ST_CSTART: state_nxt = ddob_pkg::ST_CWAIT;
      ddob_pkg::ST_CWAIT: begin
        if (crd_sts.done) begin
          state_nxt = ddob_pkg::ST_XMUL;
        end
      end
      ddob_pkg::ST_XMUL:   state_nxt = ddob_pkg::ST_YMUL;
      ddob_pkg::ST_YMUL:   state_nxt = ddob_pkg::ST_XADD;
      ddob_pkg::ST_XADD:   state_nxt = ddob_pkg::ST_YADD;
      ddob_pkg::ST_YADD:   state_nxt = ddob_pkg::ST_DONE;
      ddob_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = ddob_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = ddob_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_ticks_r <= ddob_pkg::SAMPLE_TICKS_RST;
      duty_start_r   <= ddob_pkg::DUTY_START_RST;
      tick_angle_r   <= ddob_pkg::TICK_ANGLE_RST;
    end else if (cfg_we) begin
      case (ddob_pkg::reg_index_t'(cfg_index))
        ddob_pkg::REG_SAMPLE_TICKS:     sample_ticks_r <= cfg_wdata[7:0];
        ddob_pkg::REG_RIGHT_DUTY_START: duty_start_r   <= cfg_wdata[7:0];
        ddob_pkg::REG_TICK_ANGLE:       tick_angle_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // run state and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ddob_pkg::ST_IDLE;
      running_r     <= 1'b0;
      time_count_r  <= '0;
      total_left_r  <= '0;
      total_right_r <= '0;
      win_left_r    <= '0;
      win_right_r   <= '0;
      duty_r        <= '0;
      heading_r     <= '0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      goal_r        <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ddob_pkg::ST_IDLE: begin
          if (accept) begin
            case (op)
              ddob_pkg::OP_START: begin
                running_r     <= 1'b1;
                time_count_r  <= '0;
                total_left_r  <= '0;
                total_right_r <= '0;
                win_left_r    <= '0;
                win_right_r   <= '0;
                heading_r     <= '0;
                pos_x_r       <= '0;
                pos_y_r       <= '0;
                goal_r        <= in_target_ticks;
                duty_r        <= duty_start_r;
              end
              ddob_pkg::OP_LEFT: begin
                if (running_r) begin
                  if (total_left_r != 16'hFFFF) total_left_r <= total_left_r + 16'd1;
                  if (win_left_r != 12'hFFF) win_left_r <= win_left_r + 12'd1;
                end
              end
              ddob_pkg::OP_RIGHT: begin
                if (running_r) begin
                  if (total_right_r != 16'hFFFF) total_right_r <= total_right_r + 16'd1;
                  if (win_right_r != 12'hFFF) win_right_r <= win_right_r + 12'd1;
                end
              end
              ddob_pkg::OP_TIME: begin
                if (running_r) begin
                  time_count_r <= win_end ? 8'd0 : tc_inc;
                  if (win_end) begin
                    if (win_left_r > win_right_r && duty_r != 8'hFF) begin
                      duty_r <= duty_r + 8'd1;
                    end else if (win_left_r < win_right_r && duty_r != 8'h00) begin
                      duty_r <= duty_r - 8'd1;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ddob_pkg::ST_HEAD: heading_r <= heading_r + prod[15:0];
        ddob_pkg::ST_XADD: pos_x_r   <= pos_sat;
        ddob_pkg::ST_YADD: pos_y_r   <= pos_sat;
        ddob_pkg::ST_DONE: begin
          if (load_out) begin
            win_left_r  <= '0;
            win_right_r <= '0;
            if (fin) begin
              running_r     <= 1'b0;
              time_count_r  <= '0;
              total_left_r  <= '0;
              total_right_r <= '0;
              heading_r     <= '0;
              pos_x_r       <= '0;
              pos_y_r       <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // window datapath: half tick sum and rounded products
  always_ff @(posedge clk) begin
    if (accept && win_end) begin
      half_r <= HALF_W'({1'b0, win_left_r} + {1'b0, win_right_r}) << (FRAC_BITS - 1);
    end
    if (state_r == ddob_pkg::ST_YMUL || state_r == ddob_pkg::ST_XADD) begin
      sc_r <= sc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_wl_r      <= win_left_r;
      out_wr_r      <= win_right_r;
      out_duty_r    <= duty_r;
      out_tdiff_r   <= $signed({1'b0, total_left_r}) - $signed({1'b0, total_right_r});
      out_bearing_r <= heading_r;
      out_x_r       <= pos_x_r;
      out_y_r       <= pos_y_r;
      out_fin_r     <= fin;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_window_left     = out_wl_r;
  assign out_window_right    = out_wr_r;
  assign out_right_duty      = out_duty_r;
  assign out_tick_difference = out_tdiff_r;
  assign out_bearing         = out_bearing_r;
  assign out_x_pos           = out_x_r;
  assign out_y_pos           = out_y_r;
  assign out_finished        = out_fin_r;

  `DDOB_ASSERT(a_busy_in_run, (state_r != ddob_pkg::ST_IDLE) |-> running_r,
    "window sequencer busy outside a run")
  `DDOB_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == ddob_pkg::ST_DONE),
    "result raised without a completed window")
  `DDOB_ASSERT(a_fin_clears, ($rose(out_valid_r) && out_fin_r) |-> !running_r,
    "finishing window left the run active")
  `DDOB_ASSERT(a_duty_hold, (state_r != ddob_pkg::ST_IDLE) |=> (duty_r == $past(duty_r)),
    "duty changed during window processing")
  `DDOB_ASSERT(a_cordic_idle, (state_r == ddob_pkg::ST_CSTART) |-> !crd_sts.busy,
    "rotation unit started while busy")

endmodule
